// ----- sv/cdts_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the clock date/time setter.
// Used by cdts_step, clock_date_time_setter_core and its checker; no dependencies.
package cdts_pkg;

   // Button / load command codes
   localparam logic [2:0] CMD_NONE  = 3'd0;
   localparam logic [2:0] CMD_PLUS  = 3'd1;
   localparam logic [2:0] CMD_MINUS = 3'd2;
   localparam logic [2:0] CMD_MODE  = 3'd3;
   localparam logic [2:0] CMD_LOAD  = 3'd4;

   // Result status codes
   localparam logic [1:0] ST_UNCHANGED = 2'd0;
   localparam logic [1:0] ST_CHANGED   = 2'd1;
   localparam logic [1:0] ST_FINISHED  = 2'd2;

   // Unreachable phase code, acts as idle
   localparam logic [2:0] PH_UNUSED = 3'd7;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_DAY     = 3'd1,
      PH_MONTH   = 3'd2,
      PH_WEEKDAY = 3'd3,
      PH_YEAR    = 3'd4,
      PH_HOURS   = 3'd5,
      PH_MINS    = 3'd6
   } phase_type;

   typedef struct packed {
      logic [5:0] secs;
      logic [5:0] mins;
      logic [4:0] hours;
      logic [2:0] weekday;
      logic [4:0] day;
      logic [3:0] month;
      logic [6:0] year;
   } fields_type;

   // Step a field up or down with wrap-around between lo and hi
   function automatic logic [6:0] step_value(input logic [6:0] v, input logic up,
                                             input logic [6:0] lo, input logic [6:0] hi);
      logic [6:0] r;
      if (up) begin
         r = (v >= hi) ? lo : v + 7'd1;
      end else begin
         r = (v <= lo) ? hi : v - 7'd1;
      end
      return r;
   endfunction

   // Every fourth year is a leap year; a day or month of zero passes
   function automatic logic date_ok(input logic [4:0] day, input logic [3:0] month,
                                    input logic [6:0] year);
      logic leap;
      logic bad;
      leap = (year[1:0] == 2'b00);
      bad  = (month == 4'd2) && ((day == 5'd30) || (day == 5'd31) ||
                                 ((day == 5'd29) && !leap));
      bad  = bad || ((day == 5'd31) && (month inside {4'd4, 4'd6, 4'd9, 4'd11}));
      return !bad;
   endfunction

endpackage

// ----- sv/clock_date_time_setter_core.sv -----
`timescale 1ns / 1ps
// Top level of the button-driven clock date/time setter.
// Depends on cdts_pkg and cdts_step.
//
// Use: each transfer on the req_ channel carries one command (none, plus,
// minus, mode or load of a clock reading). Every command produces exactly
// one transfer on the rsp_ channel with a status and the phase and field
// values after that command.
// Order: a command accepted on req_ sits in the input register, is applied
// once the result register is free, and its result is shown from then on:
// rsp_valid rises when the command is applied to the result register.
// Throughput: one command per cycle while rsp_ready is high; the field and
// phase registers are updated once per command by the combinational cdts_step.
// The result fields are the live state registers, which only move when
// the result register is free, so they hold while a result waits.
// Stall: while rsp_ready is low and a result is held, one further command
// waits in the input register and req_ready drops only when both are full.
// Reset: synchronous; phase returns to idle, all fields to zero, and both
// channels empty.
module clock_date_time_setter_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_cmd,
   input  logic [5:0] req_load_secs,
   input  logic [5:0] req_load_mins,
   input  logic [4:0] req_load_hours,
   input  logic [2:0] req_load_weekday,
   input  logic [4:0] req_load_day,
   input  logic [3:0] req_load_month,
   input  logic [6:0] req_load_year,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic [2:0] rsp_phase_now,
   output logic [5:0] rsp_secs_now,
   output logic [5:0] rsp_mins_now,
   output logic [4:0] rsp_hours_now,
   output logic [2:0] rsp_weekday_now,
   output logic [4:0] rsp_day_now,
   output logic [3:0] rsp_month_now,
   output logic [6:0] rsp_year_now
);

   logic                 in_valid_ff;
   logic [2:0]           in_cmd_ff;
   cdts_pkg::fields_type in_load_ff;
   cdts_pkg::fields_type load_in;

   logic                 out_valid_ff;
   logic [1:0]           status_ff;
   cdts_pkg::phase_type  phase_ff;
   cdts_pkg::fields_type fields_ff;

   cdts_pkg::phase_type  phase_in;
   cdts_pkg::fields_type fields_in;
   logic [1:0]           status_in;
   logic                 advance;

   assign load_in = '{secs: req_load_secs, mins: req_load_mins, hours: req_load_hours,
                      weekday: req_load_weekday, day: req_load_day,
                      month: req_load_month, year: req_load_year};

   // apply the held command once the result register is free
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   cdts_step u_step (
      .cmd         (in_cmd_ff),
      .load_fields (in_load_ff),
      .phase       (phase_ff),
      .cur         (fields_ff),
      .nxt_phase   (phase_in),
      .nxt         (fields_in),
      .status      (status_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= cdts_pkg::PH_IDLE;
         fields_ff    <= '0;
         status_ff    <= cdts_pkg::ST_UNCHANGED;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            phase_ff     <= phase_in;
            fields_ff    <= fields_in;
            status_ff    <= status_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload of the input register needs no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_cmd_ff  <= req_cmd;
         in_load_ff <= load_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_phase_now   = phase_ff;
   assign rsp_secs_now    = fields_ff.secs;
   assign rsp_mins_now    = fields_ff.mins;
   assign rsp_hours_now   = fields_ff.hours;
   assign rsp_weekday_now = fields_ff.weekday;
   assign rsp_day_now     = fields_ff.day;
   assign rsp_month_now   = fields_ff.month;
   assign rsp_year_now    = fields_ff.year;

endmodule

// ----- sv/cdts_step.sv -----
`timescale 1ns / 1ps
// One-item update of the setter: next phase, next field values and status.
// Combinational; uses types and functions from cdts_pkg.
module cdts_step (
   input  logic [2:0]          cmd,
   input  cdts_pkg::fields_type load_fields,
   input  cdts_pkg::phase_type  phase,
   input  cdts_pkg::fields_type cur,
   output cdts_pkg::phase_type  nxt_phase,
   output cdts_pkg::fields_type nxt,
   output logic [1:0]          status
);

   logic up;
   logic mode;

   assign up   = (cmd == cdts_pkg::CMD_PLUS);
   assign mode = (cmd == cdts_pkg::CMD_MODE);

   always_comb begin
      nxt_phase = phase;
      nxt       = cur;
      status    = cdts_pkg::ST_UNCHANGED;
      case (cmd)
         cdts_pkg::CMD_LOAD: begin
            nxt = load_fields;
         end
         cdts_pkg::CMD_PLUS, cdts_pkg::CMD_MINUS, cdts_pkg::CMD_MODE: begin
            status = cdts_pkg::ST_CHANGED;
            case (phase)
               cdts_pkg::PH_DAY: begin
                  if (mode) nxt_phase = cdts_pkg::PH_MONTH;
                  else nxt.day = 5'(cdts_pkg::step_value(7'(cur.day), up, 7'd1, 7'd31));
               end
               cdts_pkg::PH_MONTH: begin
                  if (mode) nxt_phase = cdts_pkg::PH_WEEKDAY;
                  else nxt.month = 4'(cdts_pkg::step_value(7'(cur.month), up, 7'd1, 7'd12));
               end
               cdts_pkg::PH_WEEKDAY: begin
                  if (mode) nxt_phase = cdts_pkg::PH_YEAR;
                  else nxt.weekday = 3'(cdts_pkg::step_value(7'(cur.weekday), up, 7'd1, 7'd7));
               end
               cdts_pkg::PH_YEAR: begin
                  if (mode) begin
                     // drop back to idle on an impossible date
                     nxt_phase = cdts_pkg::date_ok(cur.day, cur.month, cur.year) ?
                                 cdts_pkg::PH_HOURS : cdts_pkg::PH_IDLE;
                  end else begin
                     nxt.year = cdts_pkg::step_value(cur.year, up, 7'd0, 7'd99);
                  end
               end
               cdts_pkg::PH_HOURS: begin
                  if (mode) nxt_phase = cdts_pkg::PH_MINS;
                  else nxt.hours = 5'(cdts_pkg::step_value(7'(cur.hours), up, 7'd0, 7'd23));
               end
               cdts_pkg::PH_MINS: begin
                  if (mode) begin
                     nxt_phase = cdts_pkg::PH_IDLE;
                     nxt.secs  = 6'd0;
                     status    = cdts_pkg::ST_FINISHED;
                  end else begin
                     nxt.mins = 6'(cdts_pkg::step_value(7'(cur.mins), up, 7'd0, 7'd59));
                  end
               end
               default: begin
                  nxt_phase = cdts_pkg::PH_DAY;
               end
            endcase
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

// ----- sv/clock_date_time_setter_core_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for clock_date_time_setter_core, attached by bind.
// Depends on cdts_pkg for status and phase codes.
module cdts_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [2:0] rsp_phase_now,
   input logic [5:0] rsp_secs_now,
   input logic [4:0] rsp_day_now
);

   // nothing is shown straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // hold a stalled result
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
                                  $stable(rsp_phase_now) && $stable(rsp_day_now))
      else $error("stalled result changed");

   // a finished setting returns to idle with seconds cleared
   a_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == cdts_pkg::ST_FINISHED |->
         rsp_phase_now == cdts_pkg::PH_IDLE && rsp_secs_now == 6'd0)
      else $error("finish without idle and cleared seconds");

   a_no_unused_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_phase_now != cdts_pkg::PH_UNUSED && rsp_status != 2'd3)
      else $error("unused phase or status code");

endmodule

bind clock_date_time_setter_core cdts_checker u_cdts_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_status    (rsp_status),
   .rsp_phase_now (rsp_phase_now),
   .rsp_secs_now  (rsp_secs_now),
   .rsp_day_now   (rsp_day_now)
);
